// File: rtl/uftq_pkg.sv
package uftq_pkg;

  localparam int QUEUE_FRAMES = 128;
  localparam int FRAME_BYTES  = 10;
  localparam int SLOT_W       = $clog2(QUEUE_FRAMES);
  localparam int COUNT_W      = $clog2(QUEUE_FRAMES + 1);
  localparam int POS_W        = 4;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_READY = 1'b1;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] frame_byte_0;
    logic [7:0] frame_byte_1;
    logic [7:0] frame_byte_2;
    logic [7:0] frame_byte_3;
    logic [7:0] frame_byte_4;
    logic [7:0] frame_byte_5;
    logic [7:0] frame_byte_6;
    logic [7:0] frame_byte_7;
    logic [7:0] frame_byte_8;
    logic [7:0] frame_byte_9;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic       push_dropped;
    logic       idle;
    logic [7:0] frames_queued;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  function automatic slot_t next_slot(input slot_t s);
    next_slot = (s == slot_t'(QUEUE_FRAMES - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

endpackage

// File: rtl/uart_frame_transmit_queue.sv
// ring queue of fixed-size frames feeding a serial transmitter byte by byte
// input channel in_valid/in_ready/in_item: mode 0 pushes a whole frame,
// mode 1 asks for the next byte of the oldest frame
// result channel out_valid/out_ready/out_item: one result per input transaction
// frames live in a single-port-write, registered-read frame memory
// push: frame written at acceptance, result registered in the cycle after
// byte request while sending: memory read issued at acceptance, byte
// selected from the registered read data the cycle after and then
// registered into the result; the registered memory read is what makes
// a byte request slower than a push
// a full queue drops the push and flags push_dropped
// a byte request while stopped returns byte_valid 0 straight away
// reset (rst_n low, synchronous) empties the queue and stops sending;
// frame memory content is not cleared and needs no clearing pass
// a stalled receiver holds the registered result; one more transaction can
// be taken only in the cycle the held result leaves
module uart_frame_transmit_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uftq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output uftq_pkg::out_item_t out_item
);
  import uftq_pkg::*;

  state_t    state_r, state_nxt;
  slot_t     wr_slot_r, wr_slot_nxt;
  slot_t     rd_slot_r, rd_slot_nxt;
  pos_t      pos_r, pos_nxt;
  count_t    count_r, count_nxt;
  logic      sending_r, sending_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  out_item_t pend_r, pend_nxt;
  pos_t      sel_r, sel_nxt;

  logic      out_free;
  logic      in_fire;
  logic      mem_wr_en;
  logic      mem_rd_en;
  frame_t    wr_frame;
  frame_t    rd_frame;
  logic [9:0][7:0] all_bytes;
  pos_t      bp;

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  uftq_frame_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_slot_r),
    .wr_data (wr_frame),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_slot_r),
    .rd_data (rd_frame)
  );

  always_comb begin
    all_bytes[0] = in_item.frame_byte_0;
    all_bytes[1] = in_item.frame_byte_1;
    all_bytes[2] = in_item.frame_byte_2;
    all_bytes[3] = in_item.frame_byte_3;
    all_bytes[4] = in_item.frame_byte_4;
    all_bytes[5] = in_item.frame_byte_5;
    all_bytes[6] = in_item.frame_byte_6;
    all_bytes[7] = in_item.frame_byte_7;
    all_bytes[8] = in_item.frame_byte_8;
    all_bytes[9] = in_item.frame_byte_9;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      wr_frame[i] = all_bytes[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_item.mode == MODE_READY && sending_r) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready  = 1'b0;
    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = out_free;
        mem_wr_en = in_fire && in_item.mode == MODE_PUSH &&
                    count_r < count_t'(QUEUE_FRAMES);
        mem_rd_en = in_fire && in_item.mode == MODE_READY && sending_r;
      end
      ST_READ: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // queue bookkeeping and result
  always_comb begin
    wr_slot_nxt   = wr_slot_r;
    rd_slot_nxt   = rd_slot_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    sending_nxt   = sending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    pend_nxt      = pend_r;
    sel_nxt       = sel_r;
    bp            = (pos_r >= pos_t'(FRAME_BYTES)) ? pos_t'(FRAME_BYTES - 1) : pos_r;

    if (in_fire) begin
      out_item_nxt = '0;
      if (in_item.mode == MODE_PUSH) begin
        if (count_r >= count_t'(QUEUE_FRAMES)) begin
          out_item_nxt.push_dropped = 1'b1;
        end else begin
          wr_slot_nxt = next_slot(wr_slot_r);
          count_nxt   = count_t'(count_r + 1'b1);
          if (!sending_r) begin
            sending_nxt = 1'b1;
            pos_nxt     = '0;
          end
        end
      end else if (sending_r) begin
        pend_nxt            = '0;
        pend_nxt.byte_valid = 1'b1;
        sel_nxt             = bp;
        if (pos_t'(bp + 1'b1) >= pos_t'(FRAME_BYTES)) begin
          pend_nxt.frame_last = 1'b1;
          pos_nxt             = '0;
          rd_slot_nxt         = next_slot(rd_slot_r);
          if (count_r > '0) begin
            count_nxt = count_t'(count_r - 1'b1);
          end
          if (count_nxt == '0) begin
            sending_nxt = 1'b0;
          end
        end else begin
          pos_nxt = pos_t'(bp + 1'b1);
        end
      end
      out_item_nxt.idle          = !sending_nxt && count_nxt == '0;
      out_item_nxt.frames_queued = 8'(count_nxt);
      pend_nxt.idle              = out_item_nxt.idle;
      pend_nxt.frames_queued     = out_item_nxt.frames_queued;
      if (in_item.mode == MODE_PUSH || !sending_r) begin
        out_valid_nxt = 1'b1;
      end
    end

    if (state_r == ST_READ && out_free) begin
      out_valid_nxt        = 1'b1;
      out_item_nxt         = pend_r;
      out_item_nxt.tx_byte = rd_frame[sel_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_slot_r   <= wr_slot_nxt;
      rd_slot_r   <= rd_slot_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      sending_r   <= sending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    pend_r     <= pend_nxt;
    sel_r      <= sel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/uftq_frame_mem.sv
module uftq_frame_mem (
  input  logic             clk,
  input  logic             wr_en,
  input  uftq_pkg::slot_t  wr_addr,
  input  uftq_pkg::frame_t wr_data,
  input  logic             rd_en,
  input  uftq_pkg::slot_t  rd_addr,
  output uftq_pkg::frame_t rd_data
);
  import uftq_pkg::*;

  frame_t mem [QUEUE_FRAMES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
